/* hdl/half_float_mixed_dot_product_defines.svh */
// ---------------------------------------------------------------------------
// half_float_mixed_dot_product_defines
// assertion macros for the mixed precision dot product checker
// ---------------------------------------------------------------------------
`ifndef HALF_FLOAT_MIXED_DOT_PRODUCT_DEFINES_SVH
`define HALF_FLOAT_MIXED_DOT_PRODUCT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define HFDP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define HFDP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/hfdp_pkg.sv */
// ---------------------------------------------------------------------------
// hfdp_pkg
// shared types and constants of the mixed precision dot product
// ---------------------------------------------------------------------------
package hfdp_pkg;

    typedef logic [63:0] dbl_t;
    typedef logic [31:0] sgl_t;

    localparam logic [10:0] DBL_EXP_ALL = 11'h7FF;
    localparam dbl_t        DBL_QNAN    = 64'h7FF8_0000_0000_0000;
    localparam sgl_t        SGL_QNAN    = 32'h7FC0_0000;
    localparam logic [7:0]  SGL_EXP_ALL = 8'hFF;

endpackage

/* hdl/hfdp_mul.sv */
// ---------------------------------------------------------------------------
// hfdp_mul
// widens the half operand and forms the exact product as a binary64
// ---------------------------------------------------------------------------
module hfdp_mul
(
    input  logic [31:0]   query_bits,
    input  logic [15:0]   base_half_bits,
    output hfdp_pkg::dbl_t prod
);
    import hfdp_pkg::*;

    logic        sq, sh, sp;
    logic [7:0]  eq;
    logic [22:0] fq;
    logic [4:0]  eh;
    logic [9:0]  fh;
    logic        q_nan, q_inf, q_zero, h_nan, h_inf, h_zero;
    logic [23:0] mq;
    logic [10:0] mh;
    logic [34:0] p;
    logic [34:0] p_norm;
    logic [5:0]  lz;
    logic [7:0]  eq_eff;
    logic [4:0]  eh_eff;
    logic [10:0] e_res;

    assign sq = query_bits[31];
    assign eq = query_bits[30:23];
    assign fq = query_bits[22:0];
    assign sh = base_half_bits[15];
    assign eh = base_half_bits[14:10];
    assign fh = base_half_bits[9:0];
    assign sp = sq ^ sh;

    assign q_nan  = (eq == 8'hFF) && (fq != 23'd0);
    assign q_inf  = (eq == 8'hFF) && (fq == 23'd0);
    assign q_zero = (eq == 8'd0) && (fq == 23'd0);
    assign h_nan  = (eh == 5'h1F) && (fh != 10'd0);
    assign h_inf  = (eh == 5'h1F) && (fh == 10'd0);
    assign h_zero = (eh == 5'd0) && (fh == 10'd0);

    // subnormals take the minimum exponent and no hidden bit
    assign mq     = {eq != 8'd0, fq};
    assign mh     = {eh != 5'd0, fh};
    assign eq_eff = (eq == 8'd0) ? 8'd1 : eq;
    assign eh_eff = (eh == 5'd0) ? 5'd1 : eh;

    assign p = 35'(mq) * 35'(mh);

    // leading zero count of the raw product
    always_comb
    begin
        lz = 6'd35;
        for (int i = 0; i < 35; i++)
        begin
            if (p[i])
            begin
                lz = 6'(34 - i);
            end
        end
    end

    assign p_norm = p << lz;
    // 1023 - 127 - 15 + 1 folded into one bias
    assign e_res  = 11'(eq_eff) + 11'(eh_eff) + 11'd882 - 11'(lz);

    always_comb
    begin
        if (q_nan || h_nan || (q_inf && h_zero) || (h_inf && q_zero))
        begin
            prod = DBL_QNAN;
        end
        else if (q_inf || h_inf)
        begin
            prod = {sp, DBL_EXP_ALL, 52'd0};
        end
        else if (q_zero || h_zero)
        begin
            prod = {sp, 63'd0};
        end
        else
        begin
            prod = {sp, e_res, p_norm[33:0], 18'd0};
        end
    end

endmodule

/* hdl/hfdp_add.sv */
// ---------------------------------------------------------------------------
// hfdp_add
// binary64 adder with round to nearest even
// ---------------------------------------------------------------------------
module hfdp_add
(
    input  hfdp_pkg::dbl_t a,
    input  hfdp_pkg::dbl_t b,
    output hfdp_pkg::dbl_t s
);
    import hfdp_pkg::*;

    logic        a_nan, b_nan, a_inf, b_inf, a_big, sub;
    dbl_t        x, y;
    logic        sx;
    logic [10:0] ex_eff, ey_eff, d;
    logic [52:0] mx, my;
    logic [55:0] xw, yw, yal, mask;
    logic [56:0] sum;
    logic [5:0]  lz, sh;
    logic [10:0] lim;
    logic [55:0] n;
    logic [11:0] e;
    logic [62:0] packed_v;
    logic        inc;

    assign a_nan = (a[62:52] == DBL_EXP_ALL) && (a[51:0] != 52'd0);
    assign b_nan = (b[62:52] == DBL_EXP_ALL) && (b[51:0] != 52'd0);
    assign a_inf = (a[62:52] == DBL_EXP_ALL) && (a[51:0] == 52'd0);
    assign b_inf = (b[62:52] == DBL_EXP_ALL) && (b[51:0] == 52'd0);

    // larger magnitude first
    assign a_big = a[62:0] >= b[62:0];
    assign x     = a_big ? a : b;
    assign y     = a_big ? b : a;
    assign sx    = x[63];
    assign sub   = x[63] ^ y[63];

    assign ex_eff = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    assign ey_eff = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
    assign mx     = {x[62:52] != 11'd0, x[51:0]};
    assign my     = {y[62:52] != 11'd0, y[51:0]};
    assign d      = ex_eff - ey_eff;

    // alignment with guard, round and sticky
    assign xw   = {mx, 3'b000};
    assign yw   = {my, 3'b000};
    assign mask = (d >= 11'd56) ? {56{1'b1}} : ~({56{1'b1}} << d[5:0]);
    assign yal  = (d >= 11'd56) ? {55'd0, |my}
                                : ((yw >> d[5:0]) | {55'd0, |(yw & mask)});

    assign sum = sub ? ({1'b0, xw} - {1'b0, yal}) : ({1'b0, xw} + {1'b0, yal});

    always_comb
    begin
        lz = 6'd56;
        for (int i = 0; i < 56; i++)
        begin
            if (sum[i])
            begin
                lz = 6'(55 - i);
            end
        end
    end

    // no shift below the minimum exponent, gradual underflow
    assign lim = ex_eff - 11'd1;
    assign sh  = (11'(lz) > lim) ? lim[5:0] : lz;

    always_comb
    begin
        if (sum[56])
        begin
            n = {sum[56:2], sum[1] | sum[0]};
            e = 12'(ex_eff) + 12'd1;
        end
        else
        begin
            n = sum[55:0] << sh;
            e = 12'(ex_eff) - 12'(sh);
        end
    end

    assign inc      = n[2] & (n[1] | n[0] | n[3]);
    assign packed_v = {(n[55] ? e[10:0] : 11'd0), n[54:3]};

    always_comb
    begin
        if (a_nan || b_nan || (a_inf && b_inf && (a[63] != b[63])))
        begin
            s = DBL_QNAN;
        end
        else if (a_inf)
        begin
            s = a;
        end
        else if (b_inf)
        begin
            s = b;
        end
        else if (n == 56'd0)
        begin
            s = {sub ? 1'b0 : sx, 63'd0};
        end
        else if (e >= 12'h7FF)
        begin
            s = {sx, DBL_EXP_ALL, 52'd0};
        end
        else
        begin
            s = {sx, packed_v + 63'(inc)};
        end
    end

endmodule

/* hdl/hfdp_narrow.sv */
// ---------------------------------------------------------------------------
// hfdp_narrow
// rounds a binary64 sum to binary32, nearest even, canonical nan
// ---------------------------------------------------------------------------
module hfdp_narrow
(
    input  hfdp_pkg::dbl_t d,
    output hfdp_pkg::sgl_t r
);
    import hfdp_pkg::*;

    logic         sd;
    logic [10:0]  ed, ed_eff, e32, shf;
    logic [51:0]  fd;
    logic [52:0]  md;
    logic [6:0]   shc;
    logic [107:0] wide;
    logic         inc_n, inc_s;

    assign sd = d[63];
    assign ed = d[62:52];
    assign fd = d[51:0];
    assign md = {ed != 11'd0, fd};

    assign e32   = ed - 11'd896;
    assign inc_n = fd[28] & ((|fd[27:0]) | fd[29]);

    // subnormal range, shift into units of the smallest binary32 step
    assign ed_eff = (ed == 11'd0) ? 11'd1 : ed;
    assign shf    = 11'd926 - ed_eff;
    assign shc    = (shf > 11'd107) ? 7'd107 : shf[6:0];
    assign wide   = {md, 55'd0} >> shc;
    assign inc_s  = wide[54] & ((|wide[53:0]) | wide[55]);

    always_comb
    begin
        if (ed == DBL_EXP_ALL && fd != 52'd0)
        begin
            r = SGL_QNAN;
        end
        else if (ed >= 11'd1151)
        begin
            r = {sd, SGL_EXP_ALL, 23'd0};
        end
        else if (ed >= 11'd897)
        begin
            r = {sd, e32[7:0], fd[51:29]} + 32'(inc_n);
        end
        else
        begin
            r = {sd, 8'd0, wide[77:55]} + 32'(inc_s);
        end
    end

endmodule

/* hdl/half_float_mixed_dot_product.sv */
// ---------------------------------------------------------------------------
// half_float_mixed_dot_product
// binary32 by binary16 dot product with a binary64 running sum
// ---------------------------------------------------------------------------
// path: a last element taken at the input reaches dot_bits through the input
//   register, product register, sum register and output register
// throughput: one element per cycle while elem_stall is low, set by the
//   combinational binary64 add that closes the accumulate loop
// reset: all valid flags clear and the running sum returns to +0.0
// ---------------------------------------------------------------------------
module half_float_mixed_dot_product
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        elem_valid,
    output logic        elem_stall,
    input  logic [31:0] query_bits,
    input  logic [15:0] base_half_bits,
    input  logic        last_element,
    output logic        dot_valid,
    input  logic        dot_stall,
    output logic [31:0] dot_bits
);
    import hfdp_pkg::*;

    // input register
    logic        a_valid_reg, a_valid_next;
    logic [31:0] a_query_reg;
    logic [15:0] a_half_reg;
    logic        a_last_reg;
    // product register
    logic        b_valid_reg, b_valid_next;
    dbl_t        b_prod_reg;
    logic        b_last_reg;
    // running sum and finished sum
    dbl_t        acc_reg, acc_next;
    logic        c_valid_reg, c_valid_next;
    dbl_t        c_sum_reg;
    // result register
    logic        dot_valid_reg, dot_valid_next;
    sgl_t        dot_bits_reg;

    dbl_t        prod, sum;
    sgl_t        narrowed;
    logic        out_free, c_ready, b_fire, b_ready, a_ready, elem_fire;

    hfdp_mul u_mul
    (
        .query_bits     (a_query_reg),
        .base_half_bits (a_half_reg),
        .prod           (prod)
    );

    // accumulate loop: one binary64 add per cycle unless the product stage is held
    hfdp_add u_add
    (
        .a (acc_reg),
        .b (b_prod_reg),
        .s (sum)
    );

    hfdp_narrow u_narrow
    (
        .d (c_sum_reg),
        .r (narrowed)
    );

    // each stage moves when empty or when the stage after it takes its word;
    // non-last products retire into the sum without waiting on the output
    assign out_free  = !dot_valid_reg || !dot_stall;
    assign c_ready   = !c_valid_reg || out_free;
    assign b_fire    = b_valid_reg && (!b_last_reg || c_ready);
    assign b_ready   = !b_valid_reg || b_fire;
    assign a_ready   = !a_valid_reg || b_ready;
    assign elem_fire = elem_valid && a_ready;

    assign elem_stall = !a_ready;
    assign dot_valid  = dot_valid_reg;
    assign dot_bits   = dot_bits_reg;

    always_comb
    begin
        a_valid_next   = a_ready ? elem_valid : a_valid_reg;
        b_valid_next   = b_ready ? a_valid_reg : b_valid_reg;
        c_valid_next   = c_ready ? (b_fire && b_last_reg) : c_valid_reg;
        dot_valid_next = out_free ? c_valid_reg : dot_valid_reg;
        acc_next       = acc_reg;
        if (b_fire)
        begin
            // the last element clears the sum back to +0.0
            acc_next = b_last_reg ? 64'd0 : sum;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            dot_valid_reg <= 1'b0;
            acc_reg       <= 64'd0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            dot_valid_reg <= dot_valid_next;
            acc_reg       <= acc_next;
        end
    end

    // payload, loaded only when its stage takes a new word
    always_ff @(posedge clk)
    begin
        if (elem_fire)
        begin
            a_query_reg <= query_bits;
            a_half_reg  <= base_half_bits;
            a_last_reg  <= last_element;
        end
        if (b_ready && a_valid_reg)
        begin
            b_prod_reg <= prod;
            b_last_reg <= a_last_reg;
        end
        if (c_ready && b_fire && b_last_reg)
        begin
            c_sum_reg <= sum;
        end
        if (out_free && c_valid_reg)
        begin
            dot_bits_reg <= narrowed;
        end
    end

endmodule

/* hdl/hfdp_checker.sv */
// ---------------------------------------------------------------------------
// hfdp_checker
// port level checks on the dot product, bound to the top level
// ---------------------------------------------------------------------------
`include "half_float_mixed_dot_product_defines.svh"

module hfdp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        elem_valid,
    input logic        elem_stall,
    input logic        dot_valid,
    input logic        dot_stall,
    input logic [31:0] dot_bits
);

    // a stalled result word stays
    `HFDP_ASSERT_NXT(a_dot_hold, dot_valid && dot_stall, dot_valid && $stable(dot_bits), "dot word dropped or changed under stall")

    // nan results leave in one canonical form
    `HFDP_ASSERT_IMP(a_nan_canon, dot_valid && dot_bits[30:23] == 8'hFF && dot_bits[22:0] != 23'd0, dot_bits == 32'h7FC00000, "non canonical nan")

    // the input only backs up when a finished word is held at the output
    `HFDP_ASSERT_IMP(a_stall_cause, elem_stall, dot_valid && dot_stall, "input stalled without output back pressure")

    // no word appears from reset before anything could have produced it
    `HFDP_ASSERT_NXT(a_out_rise, !dot_valid && !elem_valid && !elem_stall && $past(!elem_valid) && $past(!elem_valid, 2) && $past(!elem_valid, 3), !dot_valid, "dot word with no element taken")

endmodule

bind half_float_mixed_dot_product hfdp_checker u_hfdp_checker (.*);
